// ----- rtl/ccs_pkg.sv -----
// Shared types and constants for the cell to ANSI colour stream encoder.
// Used by the front end, the command queue, the back end and the top level.
`default_nettype none

package ccs_pkg;

  // One character cell as it arrives on the input channel.
  typedef struct packed {
    logic [7:0] cell_char;
    logic [3:0] back_color;
    logic [3:0] fore_color;
  } cell_in_t;

  // One byte of the terminal stream on the output channel.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_end;
  } byte_out_t;

  // A classified cell, passed from the front end to the back end.
  typedef struct packed {
    logic [7:0] ch;
    logic       open;
    logic       bg_new;
    logic [3:0] bg;
    logic       fg_new;
    logic [3:0] fg;
    logic       nl;
    logic       nul;
  } cmd_t;

  // Position counters and the size registers.
  localparam int unsigned POS_W = 10;

  // Command queue depth and its pointer width.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  // Configuration register indexes.
  localparam logic REG_COLUMNS = 1'b0;
  localparam logic REG_ROWS    = 1'b1;

  // Register reset values.
  localparam logic [POS_W-1:0] COLUMNS_RESET = 10'd80;
  localparam logic [POS_W-1:0] ROWS_RESET    = 10'd25;

  // Character shown in place of a zero byte.
  localparam logic [7:0] CHAR_HASH = 8'h23;

endpackage : ccs_pkg

`default_nettype wire

// ----- rtl/ccs_front.sv -----
// Front end: configuration registers, position and colour tracking, and cell
// classification into commands. Depends on ccs_pkg.
`default_nettype none

module ccs_front (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_ready,
  input  ccs_pkg::cell_in_t in_data,
  input  wire               psel,
  input  wire               penable,
  input  wire               pwrite,
  input  wire  [2:0]        paddr,
  input  wire  [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output logic              push_valid,
  input  wire               push_ready,
  output ccs_pkg::cmd_t     push_data
);
  import ccs_pkg::*;

  logic [POS_W-1:0] columns_r;
  logic [POS_W-1:0] rows_r;
  logic [3:0]       prev_back_r, prev_back_nxt;
  logic [3:0]       prev_fore_r, prev_fore_nxt;
  logic [POS_W-1:0] col_pos_r, col_pos_nxt;
  logic [POS_W-1:0] row_pos_r, row_pos_nxt;

  logic             accept;
  logic             cfg_write;
  logic             reg_index;
  logic             open;
  logic [3:0]       pb, pf;
  logic             bg_new, fg_new;
  logic [POS_W-1:0] col_inc, row_inc;
  logic             nl, nul;

  // The register port never stalls.
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;
  assign reg_index = paddr[2];

  // Register read back.
  always_comb begin
    unique case (reg_index)
      REG_COLUMNS: prdata = {22'd0, columns_r};
      REG_ROWS:    prdata = {22'd0, rows_r};
      default:     prdata = 32'd0;
    endcase
  end

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      columns_r <= COLUMNS_RESET;
      rows_r    <= ROWS_RESET;
    end else if (cfg_write) begin
      unique case (reg_index)
        REG_COLUMNS: columns_r <= pwdata[POS_W-1:0];
        REG_ROWS:    rows_r    <= pwdata[POS_W-1:0];
        default:     columns_r <= columns_r;
      endcase
    end
  end

  // Handshake: a word is taken whenever the queue has room.
  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid & push_ready;

  // Classify the cell against the remembered colours and position.
  always_comb begin
    open    = (col_pos_r == '0) && (row_pos_r == '0);
    pb      = open ? 4'd0 : prev_back_r;
    pf      = open ? 4'd0 : prev_fore_r;
    bg_new  = (in_data.back_color != 4'd0) && (in_data.back_color != pb);
    fg_new  = (in_data.fore_color != 4'd0) && (in_data.fore_color != pf);
    col_inc = col_pos_r + 1'b1;
    row_inc = row_pos_r + 1'b1;
    nl      = (col_inc == columns_r);
    nul     = nl && (row_inc == rows_r);

    prev_back_nxt = bg_new ? in_data.back_color : pb;
    prev_fore_nxt = fg_new ? in_data.fore_color : pf;
    col_pos_nxt   = nl ? '0 : col_inc;
    row_pos_nxt   = nl ? (nul ? '0 : row_inc) : row_pos_r;

    push_data.ch     = (in_data.cell_char == 8'd0) ? CHAR_HASH : in_data.cell_char;
    push_data.open   = open;
    push_data.bg_new = bg_new;
    push_data.bg     = in_data.back_color;
    push_data.fg_new = fg_new;
    push_data.fg     = in_data.fore_color;
    push_data.nl     = nl;
    push_data.nul    = nul;
  end

  // Tracking state advances once per accepted cell.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_back_r <= '0;
      prev_fore_r <= '0;
      col_pos_r   <= '0;
      row_pos_r   <= '0;
    end else if (accept) begin
      prev_back_r <= prev_back_nxt;
      prev_fore_r <= prev_fore_nxt;
      col_pos_r   <= col_pos_nxt;
      row_pos_r   <= row_pos_nxt;
    end
  end

endmodule : ccs_front

`default_nettype wire

// ----- rtl/ccs_queue.sv -----
// Short command queue between the front end and the back end.
// Depends on ccs_pkg for the command type and the depth.
`default_nettype none

module ccs_queue (
  input  wire           clk,
  input  wire           rst_n,
  input  wire           push_valid,
  output logic          push_ready,
  input  ccs_pkg::cmd_t push_data,
  output logic          pop_valid,
  input  wire           pop,
  output ccs_pkg::cmd_t pop_data
);
  import ccs_pkg::*;

  cmd_t              entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r, count_nxt;
  logic              do_push, do_pop;

  assign push_ready = (count_r != QUEUE_DEPTH[QPTR_W:0]);
  assign pop_valid  = (count_r != '0);
  assign pop_data   = entry_r[rd_ptr_r];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop & pop_valid;

  // Occupancy follows pushes and pops.
  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Pointers and count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule : ccs_queue

`default_nettype wire

// ----- rtl/ccs_back.sv -----
// Back end: expands one command into its bytes, one per cycle unless the
// output stalls, into a registered output word. Depends on ccs_pkg.
`default_nettype none

module ccs_back (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                cmd_valid,
  output logic               cmd_pop,
  input  ccs_pkg::cmd_t      cmd_data,
  output logic               out_valid,
  input  wire                out_ready,
  output ccs_pkg::byte_out_t out_data
);
  import ccs_pkg::*;

  // Byte positions within the expansion of one cell.
  localparam logic [3:0] SLOT_RST_ESC = 4'd0;
  localparam logic [3:0] SLOT_RST_BRK = 4'd1;
  localparam logic [3:0] SLOT_RST_ZERO = 4'd2;
  localparam logic [3:0] SLOT_RST_M   = 4'd3;
  localparam logic [3:0] SLOT_SGR_ESC = 4'd4;
  localparam logic [3:0] SLOT_SGR_BRK = 4'd5;
  localparam logic [3:0] SLOT_BG_HUND = 4'd6;
  localparam logic [3:0] SLOT_BG_TENS = 4'd7;
  localparam logic [3:0] SLOT_BG_ONES = 4'd8;
  localparam logic [3:0] SLOT_SEMI    = 4'd9;
  localparam logic [3:0] SLOT_FG_TENS = 4'd10;
  localparam logic [3:0] SLOT_FG_ONES = 4'd11;
  localparam logic [3:0] SLOT_SGR_M   = 4'd12;
  localparam logic [3:0] SLOT_CHAR    = 4'd13;
  localparam logic [3:0] SLOT_NL      = 4'd14;
  localparam logic [3:0] SLOT_NUL     = 4'd15;

  localparam logic [7:0] ASCII_ESC  = 8'h1B;
  localparam logic [7:0] ASCII_BRK  = 8'h5B;
  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_ONE  = 8'h31;
  localparam logic [7:0] ASCII_THREE = 8'h33;
  localparam logic [7:0] ASCII_FOUR = 8'h34;
  localparam logic [7:0] ASCII_NINE = 8'h39;
  localparam logic [7:0] ASCII_M    = 8'h6D;
  localparam logic [7:0] ASCII_SEMI = 8'h3B;
  localparam logic [7:0] ASCII_NL   = 8'h0A;
  localparam logic [7:0] ASCII_NUL  = 8'h00;

  // Which byte positions a command produces.
  function automatic logic [15:0] slot_mask(input cmd_t c);
    logic [15:0] m;
    logic        sgr;
    sgr = c.bg_new | c.fg_new;
    m = '0;
    m[SLOT_RST_ESC]  = c.open;
    m[SLOT_RST_BRK]  = c.open;
    m[SLOT_RST_ZERO] = c.open;
    m[SLOT_RST_M]    = c.open;
    m[SLOT_SGR_ESC]  = sgr;
    m[SLOT_SGR_BRK]  = sgr;
    m[SLOT_BG_HUND]  = c.bg_new & c.bg[3];
    m[SLOT_BG_TENS]  = c.bg_new;
    m[SLOT_BG_ONES]  = c.bg_new;
    m[SLOT_SEMI]     = c.bg_new & c.fg_new;
    m[SLOT_FG_TENS]  = c.fg_new;
    m[SLOT_FG_ONES]  = c.fg_new;
    m[SLOT_SGR_M]    = sgr;
    m[SLOT_CHAR]     = 1'b1;
    m[SLOT_NL]       = c.nl;
    m[SLOT_NUL]      = c.nul;
    return m;
  endfunction

  cmd_t        cur_r;
  logic [15:0] mask_r;
  logic        out_valid_r;
  byte_out_t   out_data_r;

  logic [15:0] low;
  logic [15:0] rest;
  logic [3:0]  slot;
  logic        can_emit;
  logic        load;
  logic [7:0]  byte_val;

  // Pick the lowest pending position and see what remains after it.
  always_comb begin
    low  = mask_r & (~mask_r + 16'd1);
    rest = mask_r & ~low;
    slot = '0;
    for (int i = 0; i < 16; i++) begin
      if (low[i]) begin
        slot = slot | 4'(i);
      end
    end
    can_emit = (mask_r != '0) && (!out_valid_r || out_ready);
    load     = cmd_valid && ((mask_r == '0) || (can_emit && (rest == '0)));
  end

  assign cmd_pop = load;

  // Byte value for the chosen position.
  always_comb begin
    unique case (slot)
      SLOT_RST_ESC:  byte_val = ASCII_ESC;
      SLOT_RST_BRK:  byte_val = ASCII_BRK;
      SLOT_RST_ZERO: byte_val = ASCII_ZERO;
      SLOT_RST_M:    byte_val = ASCII_M;
      SLOT_SGR_ESC:  byte_val = ASCII_ESC;
      SLOT_SGR_BRK:  byte_val = ASCII_BRK;
      SLOT_BG_HUND:  byte_val = ASCII_ONE;
      SLOT_BG_TENS:  byte_val = cur_r.bg[3] ? ASCII_ZERO : ASCII_FOUR;
      SLOT_BG_ONES:  byte_val = ASCII_ZERO | {5'd0, cur_r.bg[2:0]};
      SLOT_SEMI:     byte_val = ASCII_SEMI;
      SLOT_FG_TENS:  byte_val = cur_r.fg[3] ? ASCII_NINE : ASCII_THREE;
      SLOT_FG_ONES:  byte_val = ASCII_ZERO | {5'd0, cur_r.fg[2:0]};
      SLOT_SGR_M:    byte_val = ASCII_M;
      SLOT_CHAR:     byte_val = cur_r.ch;
      SLOT_NL:       byte_val = ASCII_NL;
      SLOT_NUL:      byte_val = ASCII_NUL;
      default:       byte_val = ASCII_NUL;
    endcase
  end

  // Sequencer: take the next command as the last byte of this one leaves.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else if (load) begin
      mask_r <= slot_mask(cmd_data);
    end else if (can_emit) begin
      mask_r <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_r <= cmd_data;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (can_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (can_emit) begin
      out_data_r.out_byte <= byte_val;
      out_data_r.run_end  <= (rest == '0);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule : ccs_back

`default_nettype wire

// ----- rtl/cell_to_ansi_color_stream.sv -----
// Cell to ANSI colour stream encoder, top level. Depends on ccs_pkg,
// ccs_front, ccs_queue and ccs_back.
// Throughput: one output byte per cycle while out_ready does not hold the
// output; a cell produces 1 to 16 bytes, and the back end's single byte
// output sets this rate.
// Reset (rst_n low, synchronous) clears position, colours, queue and output.
`default_nettype none

module cell_to_ansi_color_stream (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  ccs_pkg::cell_in_t  in_data,
  output logic               out_valid,
  input  wire                out_ready,
  output ccs_pkg::byte_out_t out_data,
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire  [2:0]         paddr,
  input  wire  [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import ccs_pkg::*;

  logic push_valid, push_ready;
  cmd_t push_data;
  logic pop_valid, pop;
  cmd_t pop_data;

  // Classification and tracking.
  ccs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Decoupling queue.
  ccs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_data   (pop_data)
  );

  // Byte expansion.
  ccs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (pop_valid),
    .cmd_pop   (pop),
    .cmd_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule : cell_to_ansi_color_stream

`default_nettype wire
